// ===== sv/acas_pkg.sv =====
package acas_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int RAW_W       = 16;
	localparam int OUT_W       = 16;
	localparam int OUT_MAX_W   = 15;
	localparam int MAG_W       = OUT_W;
	localparam int QUOT_BITS   = OUT_W;
	localparam int PROD_W      = MAG_W + SAMPLE_BITS;
	localparam int CNT_W       = $clog2(QUOT_BITS);
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = 1'd1;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [SAMPLE_BITS-1:0]        smag_t;
	typedef logic signed [OUT_W-1:0]       out_t;

	// one classified transaction handed from front to back
	typedef struct packed {
		logic                  is_bound;
		out_t                  bound;
		logic [MAG_W-1:0]      mag_a;
		smag_t                 mag_b;
		smag_t                 den;
		logic                  negate;
	} cmd_t;

	// low SAMPLE_BITS of the raw word, sign taken from bit SAMPLE_BITS-1
	function automatic sample_t to_sample(input logic [RAW_W-1:0] raw);
		logic [SAMPLE_BITS+RAW_W-1:0] wide;
		wide = {{SAMPLE_BITS{1'b0}}, raw};
		return sample_t'(wide[SAMPLE_BITS-1:0]);
	endfunction

endpackage

// ===== sv/auto_calibrating_axis_scaler.sv =====
// channel   direction  handshake                      payload
// raw       in         raw_valid / raw_stall          raw_sample
// scaled    out        scaled_valid / scaled_stall    scaled_value
// cfg       in         cfg_wen (no wait)              cfg_index, cfg_data
//
// a sample that sets a new bound goes from idle straight to the hold state
// in the back end, a scaled sample a multiply state and then the bit-serial divider
// the front end takes one transaction a cycle, while the queue is not full, into a 2-entry queue
// reset clears seen_min to -1, seen_max to 1, out_min to -32768, out_max to 32767
// scaled_stall holds the result register; raw_stall rises when the queue is full
module auto_calibrating_axis_scaler (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wen,
	input  logic [acas_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [acas_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  raw_valid,
	output logic                                  raw_stall,
	input  logic signed [acas_pkg::RAW_W-1:0]     raw_sample,
	output logic                                  scaled_valid,
	input  logic                                  scaled_stall,
	output logic signed [acas_pkg::OUT_W-1:0]     scaled_value
);

	logic signed [acas_pkg::OUT_W-1:0]  out_min_q;
	logic [acas_pkg::OUT_MAX_W-1:0]     out_max_q;
	logic                               q_full;
	logic                               q_push;
	acas_pkg::cmd_t                     push_cmd;
	logic                               q_pop;
	logic                               q_valid;
	acas_pkg::cmd_t                     pop_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_min_q <= acas_pkg::OUT_W'(-32768);
			out_max_q <= acas_pkg::OUT_MAX_W'(32767);
		end else if (cfg_wen) begin
			case (cfg_index)
				acas_pkg::REG_OUT_MIN: out_min_q <= acas_pkg::OUT_W'(cfg_data);
				acas_pkg::REG_OUT_MAX: out_max_q <= cfg_data[acas_pkg::OUT_MAX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	acas_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.raw_valid  (raw_valid),
		.raw_stall  (raw_stall),
		.raw_sample (raw_sample),
		.out_min    (out_min_q),
		.out_max    (out_max_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (push_cmd)
	);

	acas_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_cmd   (pop_cmd)
	);

	acas_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_valid),
		.cmd          (pop_cmd),
		.cmd_pop      (q_pop),
		.scaled_valid (scaled_valid),
		.scaled_stall (scaled_stall),
		.scaled_value (scaled_value)
	);

endmodule

// ===== sv/acas_front.sv =====
module acas_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 raw_valid,
	output logic                                 raw_stall,
	input  logic signed [acas_pkg::RAW_W-1:0]    raw_sample,
	input  logic signed [acas_pkg::OUT_W-1:0]    out_min,
	input  logic [acas_pkg::OUT_MAX_W-1:0]       out_max,
	input  logic                                 q_full,
	output logic                                 q_push,
	output acas_pkg::cmd_t                       q_cmd
);

	acas_pkg::sample_t seen_min_q;
	acas_pkg::sample_t seen_max_q;
	acas_pkg::sample_t s;
	acas_pkg::smag_t   s_u;
	acas_pkg::smag_t   s_mag;
	acas_pkg::smag_t   min_mag;
	logic [acas_pkg::MAG_W-1:0] omin_mag;
	logic              new_max;
	logic              new_min;

	assign s        = acas_pkg::to_sample(raw_sample);
	assign s_u      = acas_pkg::smag_t'(s);
	assign s_mag    = s[acas_pkg::SAMPLE_BITS-1] ? (~s_u + 1'b1) : s_u;
	assign min_mag  = ~acas_pkg::smag_t'(seen_min_q) + 1'b1;
	assign omin_mag = out_min[acas_pkg::OUT_W-1] ?
		(~acas_pkg::MAG_W'(out_min) + 1'b1) : acas_pkg::MAG_W'(out_min);

	assign new_max = s > seen_max_q;
	assign new_min = !new_max && (s < seen_min_q);

	assign raw_stall = q_full;
	assign q_push    = raw_valid && !q_full;

	always_comb begin
		q_cmd          = '0;
		q_cmd.is_bound = new_max || new_min;
		q_cmd.bound    = new_max ? acas_pkg::out_t'({1'b0, out_max}) : out_min;
		if (s[acas_pkg::SAMPLE_BITS-1]) begin
			q_cmd.mag_a  = omin_mag;
			q_cmd.mag_b  = s_mag;
			q_cmd.den    = min_mag;
			q_cmd.negate = out_min[acas_pkg::OUT_W-1];
		end else begin
			q_cmd.mag_a  = acas_pkg::MAG_W'(out_max);
			q_cmd.mag_b  = s_u;
			q_cmd.den    = acas_pkg::smag_t'(seen_max_q);
			q_cmd.negate = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_min_q <= acas_pkg::sample_t'(-1);
			seen_max_q <= acas_pkg::sample_t'(1);
		end else if (q_push) begin
			if (new_max)
				seen_max_q <= s;
			if (new_min)
				seen_min_q <= s;
		end
	end

	// the divisors can never reach zero
	a_min_neg: assert property (@(posedge clk) disable iff (!arst_n)
		seen_min_q < 0)
		else $error("seen_min rose above -1");
	a_max_pos: assert property (@(posedge clk) disable iff (!arst_n)
		seen_max_q > 0)
		else $error("seen_max fell below 1");

endmodule

// ===== sv/acas_queue.sv =====
module acas_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  acas_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           pop_valid,
	output acas_pkg::cmd_t pop_cmd
);

	acas_pkg::cmd_t                  entry_q [acas_pkg::QDEPTH];
	logic [acas_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [acas_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [acas_pkg::QCNT_W-1:0]     count_q;

	assign full      = count_q == acas_pkg::QCNT_W'(acas_pkg::QDEPTH);
	assign pop_valid = count_q != '0;
	assign pop_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == acas_pkg::QPTR_W'(acas_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == acas_pkg::QPTR_W'(acas_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid)
		else $error("pop from empty queue");

endmodule

// ===== sv/acas_back.sv =====
module acas_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	input  acas_pkg::cmd_t                    cmd,
	output logic                              cmd_pop,
	output logic                              scaled_valid,
	input  logic                              scaled_stall,
	output logic signed [acas_pkg::OUT_W-1:0] scaled_value
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_DIV  = 4'b0100,
		S_HOLD = 4'b1000
	} back_state_t;

	back_state_t                    state_q;
	logic [acas_pkg::MAG_W-1:0]     mag_a_q;
	acas_pkg::smag_t                mag_b_q;
	acas_pkg::smag_t                den_q;
	logic                           negate_q;
	acas_pkg::smag_t                rem_q;
	logic [acas_pkg::QUOT_BITS-1:0] nq_q;
	logic [acas_pkg::CNT_W-1:0]     cnt_q;
	acas_pkg::out_t                 result_q;
	logic                           out_valid_q;
	acas_pkg::out_t                 out_value_q;

	logic [acas_pkg::PROD_W-1:0]        prod;
	logic [acas_pkg::SAMPLE_BITS+1:0]   trial;
	logic                               ge;
	logic [acas_pkg::QUOT_BITS-1:0]     quot;
	logic                               can_load;

	assign prod  = mag_a_q * mag_b_q;
	// restoring step: shift in next numerator bit, subtract if it fits
	assign trial = {1'b0, rem_q, nq_q[acas_pkg::QUOT_BITS-1]} - {2'b00, den_q};
	assign ge    = !trial[acas_pkg::SAMPLE_BITS+1];
	assign quot  = {nq_q[acas_pkg::QUOT_BITS-2:0], ge};

	assign cmd_pop      = (state_q == S_IDLE) && cmd_valid;
	assign can_load     = !out_valid_q || !scaled_stall;
	assign scaled_valid = out_valid_q;
	assign scaled_value = out_value_q;

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					mag_a_q  <= cmd.mag_a;
					mag_b_q  <= cmd.mag_b;
					den_q    <= cmd.den;
					negate_q <= cmd.negate;
					result_q <= cmd.bound;
				end
			end
			S_MUL: begin
				// quotient fits QUOT_BITS, so the top bits start as remainder
				rem_q <= prod[acas_pkg::PROD_W-1:acas_pkg::QUOT_BITS];
				nq_q  <= prod[acas_pkg::QUOT_BITS-1:0];
				cnt_q <= '0;
			end
			S_DIV: begin
				rem_q <= ge ? trial[acas_pkg::SAMPLE_BITS-1:0] :
					{rem_q[acas_pkg::SAMPLE_BITS-2:0], nq_q[acas_pkg::QUOT_BITS-1]};
				nq_q  <= quot;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == acas_pkg::CNT_W'(acas_pkg::QUOT_BITS - 1))
					result_q <= negate_q ? acas_pkg::out_t'(~quot + 1'b1) :
						acas_pkg::out_t'(quot);
			end
			default: begin
			end
		endcase
		if (state_q == S_HOLD && can_load)
			out_value_q <= result_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid)
						state_q <= cmd.is_bound ? S_HOLD : S_MUL;
				end
				S_MUL: state_q <= S_DIV;
				S_DIV: begin
					if (cnt_q == acas_pkg::CNT_W'(acas_pkg::QUOT_BITS - 1))
						state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (can_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_HOLD && can_load)
				out_valid_q <= 1'b1;
			else if (!scaled_stall)
				out_valid_q <= 1'b0;
		end
	end

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < den_q)
		else $error("divider remainder out of range");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |=> state_q == S_DIV && cnt_q == '0)
		else $error("divider did not start cleanly");

endmodule
